// ===== rtl/boundary_index_mapper_macros.svh =====
// Assertion macros for the checker file.
`ifndef BOUNDARY_INDEX_MAPPER_MACROS_SVH
`define BOUNDARY_INDEX_MAPPER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BIM_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define BIM_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bim_pkg.sv =====
package bim_pkg;
  localparam int INDEX_WIDTH_DEF  = 32;
  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int CFG_ADDR_WIDTH   = 3;

  localparam logic [1:0] MODE_CIRCULANT = 2'd0;
  localparam logic [1:0] MODE_NEUMANN   = 2'd1;
  localparam logic [1:0] MODE_DIRICHLET = 2'd2;
  localparam logic [1:0] MODE_SLIDING   = 2'd3;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;
endpackage

// ===== rtl/boundary_index_mapper.sv =====
// Boundary index mapper. Each item is a signed index that is folded onto an
// axis of the configured length, by wrap or reflection as the mode register
// selects, together with its floor period index and a negate flag. One item
// is taken in every cycle, and busy never rises. A result appears on the out_
// ports for one cycle, marked by out_valid; it passes the input register, the
// restoring divider, which resolves one quotient bit per pipeline stage, and
// the output register. The receiver cannot stall the block, so results must
// be taken as they appear. The user must write the registers only while no
// item is in flight; the block itself does not enforce this.
module boundary_index_mapper #(
  parameter int INDEX_WIDTH  = bim_pkg::INDEX_WIDTH_DEF,
  parameter int LENGTH_WIDTH = bim_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [INDEX_WIDTH-1:0]        in_raw_index,
  output logic                                 out_valid,
  output logic        [LENGTH_WIDTH-1:0]       out_mapped_index,
  output logic                                 out_negate,
  output logic signed [INDEX_WIDTH-1:0]        out_period_index,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [bim_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready
);
  import bim_pkg::*;

  localparam int NST = INDEX_WIDTH;
  localparam int RW  = LENGTH_WIDTH + 1;

  logic [1:0]              mode_r;
  logic [LENGTH_WIDTH-1:0] len_r;
  logic [LENGTH_WIDTH-1:0] m_eff;
  logic                    wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign m_eff  = (len_r == '0) ? LENGTH_WIDTH'(1) : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CIRCULANT;
      len_r  <= LENGTH_WIDTH'(1);
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE:   mode_r <= pwdata[1:0];
        REG_LENGTH: len_r  <= pwdata[LENGTH_WIDTH-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:   prdata = 32'(mode_r);
      REG_LENGTH: prdata = 32'(len_r);
      default:    prdata = '0;
    endcase
  end

  logic                    vld_r [NST+1];
  logic                    sgn_r [NST+1];
  logic [INDEX_WIDTH-1:0]  quo_r [NST+1];
  logic [RW-1:0]           rem_r [NST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
    end
    sgn_r[0] <= in_raw_index[INDEX_WIDTH-1];
    quo_r[0] <= in_raw_index[INDEX_WIDTH-1] ? ~in_raw_index : in_raw_index;
    rem_r[0] <= '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_div
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          fits;

    assign trial = {rem_r[s][LENGTH_WIDTH-1:0], quo_r[s][INDEX_WIDTH-1]};
    assign fits  = trial >= {1'b0, m_eff};
    assign diff  = trial - {1'b0, m_eff};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      sgn_r[s+1] <= sgn_r[s];
      quo_r[s+1] <= {quo_r[s][INDEX_WIDTH-2:0], fits};
      rem_r[s+1] <= fits ? diff : trial;
    end
  end

  logic [LENGTH_WIDTH-1:0] rem_fin;
  logic [LENGTH_WIDTH-1:0] mod_val;
  logic [INDEX_WIDTH-1:0]  per_val;
  logic                    odd;
  logic                    out_valid_r;
  logic [LENGTH_WIDTH-1:0] mapped_r;
  logic                    negate_r;
  logic [INDEX_WIDTH-1:0]  period_r;

  assign rem_fin = rem_r[NST][LENGTH_WIDTH-1:0];
  assign mod_val = sgn_r[NST] ? (m_eff - LENGTH_WIDTH'(1) - rem_fin) : rem_fin;
  assign per_val = sgn_r[NST] ? ~quo_r[NST] : quo_r[NST];
  assign odd     = per_val[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NST];
    end
    if (mode_r != MODE_CIRCULANT && odd) begin
      mapped_r <= m_eff - LENGTH_WIDTH'(1) - mod_val;
    end else begin
      mapped_r <= mod_val;
    end
    negate_r <= (mode_r == MODE_DIRICHLET) && odd;
    period_r <= per_val;
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_index = mapped_r;
  assign out_negate       = negate_r;
  assign out_period_index = period_r;
endmodule

// ===== rtl/boundary_index_mapper_checker.sv =====
`include "boundary_index_mapper_macros.svh"

module boundary_index_mapper_checker #(
  parameter int LAT = bim_pkg::INDEX_WIDTH_DEF + 2
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);
  `BIM_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy rose although the block never stalls")
  `BIM_ALWAYS(a_pready_high, clk, rst_n, pready, "pready dropped")
  `BIM_IMPLY(a_result_has_item, clk, rst_n, out_valid, $past(start && !busy, LAT), "result without an item at the pipeline latency")
endmodule

bind boundary_index_mapper boundary_index_mapper_checker #(
  .LAT(INDEX_WIDTH + 2)
) u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .pready   (pready)
);

// ===== bench/boundary_index_mapper_tb.sv =====
`timescale 1ns / 1ps

module boundary_index_mapper_tb;
  import bim_pkg::*;

  typedef struct packed {
    logic [15:0] mapped;
    logic        negate;
    logic [31:0] period;
  } fold_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_raw_index;
  logic        out_valid;
  logic [15:0] out_mapped_index;
  logic        out_negate;
  logic [31:0] out_period_index;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] index_queue[$];
  fold_t       fold_queue[$];
  logic [1:0]  cur_mode;
  logic [15:0] cur_length;
  int          gap_left;
  bit          calm;
  int          mismatches;

  boundary_index_mapper uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_index(in_raw_index), .out_valid(out_valid),
    .out_mapped_index(out_mapped_index), .out_negate(out_negate),
    .out_period_index(out_period_index), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint floor_div(longint x, longint d);
    if (x >= 0) return x / d;
    return (x + 1) / d - 1;
  endfunction

  function automatic fold_t fold_index(logic [31:0] raw, logic [1:0] mode,
                                       logic [15:0] len);
    longint i;
    longint m;
    longint p;
    longint j;
    fold_t  r;
    i = longint'($signed(raw));
    m = (len == 0) ? 1 : longint'(len);
    p = floor_div(i, m);
    r.negate = 1'b0;
    if (mode == MODE_CIRCULANT) begin
      j = i - p * m;
    end else begin
      j = i - floor_div(i, 2 * m) * 2 * m;
      if (j >= m) j = 2 * m - 1 - j;
      if (mode == MODE_DIRICHLET) r.negate = p[0];
    end
    r.mapped = j[15:0];
    r.period = p[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        fold_queue.push_back(fold_index(in_raw_index, cur_mode, cur_length));
        void'(index_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 18) - 1;
        start <= 1'b0;
      end else if (index_queue.size() > 0) begin
        start <= 1'b1;
        in_raw_index <= index_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    fold_t want;
    if (rst_n && out_valid) begin
      if (fold_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected item: mapped %0d", out_mapped_index);
      end else begin
        want = fold_queue.pop_front();
        if (want.mapped !== out_mapped_index || want.negate !== out_negate ||
            want.period !== out_period_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                     want.mapped, want.negate, $signed(want.period),
                     out_mapped_index, out_negate, $signed(out_period_index));
        end
      end
    end
  end

  task automatic write_reg(logic reg_sel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_MODE) cur_mode = value[1:0];
    else cur_length = value[15:0];
  endtask

  task automatic run_phase(logic [1:0] mode, logic [15:0] len, int count);
    int m;
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_LENGTH, {16'd0, len});
    m = (len == 0) ? 1 : int'(len);
    index_queue.push_back(32'd0);
    index_queue.push_back(32'hffffffff);
    index_queue.push_back(32'd1);
    index_queue.push_back(32'h7fffffff);
    index_queue.push_back(32'h80000000);
    index_queue.push_back(32'h80000001);
    index_queue.push_back(m - 1);
    index_queue.push_back(m);
    index_queue.push_back(-m);
    index_queue.push_back(-m - 1);
    index_queue.push_back(2 * m - 1);
    index_queue.push_back(2 * m);
    index_queue.push_back(-2 * m);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 2) == 0) index_queue.push_back($urandom());
      else index_queue.push_back(int'($urandom_range(0, 8 * m)) - 4 * m);
    end
    while (index_queue.size() > 0 || fold_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_raw_index = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_mode = MODE_CIRCULANT;
    cur_length = 16'd1;
    calm = 1'b0;
    mismatches = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_phase(MODE_CIRCULANT, 16'd1, 20);
    run_phase(MODE_CIRCULANT, 16'd7, 50);
    run_phase(MODE_NEUMANN, 16'd65535, 50);
    run_phase(MODE_NEUMANN, 16'd3, 50);
    run_phase(MODE_DIRICHLET, 16'd0, 40);
    run_phase(MODE_DIRICHLET, 16'd5, 60);
    run_phase(MODE_SLIDING, 16'd1, 40);
    run_phase(MODE_SLIDING, 16'd65535, 50);
    run_phase(MODE_CIRCULANT, 16'd0, 40);
    run_phase(MODE_CIRCULANT, 16'd65535, 50);
    for (int k = 0; k < 4; k++)
      run_phase(MODE_DIRICHLET - 2'(k % 3), 16'($urandom_range(2, 300)), 40);
    calm = 1'b1;
    run_phase(MODE_DIRICHLET, 16'hffff, 50);
    run_phase(MODE_SLIDING, 16'($urandom_range(1, 65535)), 50);
    if (mismatches == 0) begin
      $display("** boundary_index_mapper: PASSED **");
    end else begin
      $display("** boundary_index_mapper: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** boundary_index_mapper: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bim_pkg.sv
rtl/boundary_index_mapper.sv
rtl/boundary_index_mapper_checker.sv
bench/boundary_index_mapper_tb.sv
